FILE: sv/h264_neighbour_block_locator_core_assert.svh
// Assertion macros for the neighbour locator.
`ifndef H264_NEIGHBOUR_BLOCK_LOCATOR_CORE_ASSERT_SVH
`define H264_NEIGHBOUR_BLOCK_LOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define NBL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define NBL_ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NBL_ASSERT(lbl, prop, msg)
`define NBL_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

FILE: sv/nbl_pkg.sv
`default_nettype none
package nbl_pkg;

	localparam int ADDR_W  = 13;
	localparam int WIDTH_W = 10;
	localparam int REM_W   = WIDTH_W + 1;
	localparam int CSIZE_W = 5;

	localparam logic [1:0] REG_PIC_WIDTH = 2'd0;
	localparam logic [1:0] REG_CHROMA_W  = 2'd1;
	localparam logic [1:0] REG_CHROMA_H  = 2'd2;

	localparam logic signed [ADDR_W:0] ADDR_NONE = '1;
	localparam logic signed [4:0]      IDX_NONE  = '1;

	typedef enum logic [1:0] {
		KIND_LUMA4  = 2'd0,
		KIND_LUMA8  = 2'd1,
		KIND_CHROMA = 2'd2,
		KIND_NONE   = 2'd3
	} nbl_kind_t;

	typedef struct packed {
		logic       kill;
		logic       x_zero;
		logic       y_zero;
		logic [3:0] left_idx;
		logic [3:0] above_idx;
	} nbl_geom_t;

	typedef struct packed {
		nbl_geom_t          geom;
		logic [ADDR_W-1:0]  cur;
		logic [WIDTH_W-1:0] w;
		logic [REM_W-1:0]   rem;
	} nbl_item_t;

	// block index holding sample (x, y) of a macroblock
	function automatic logic [3:0] blk_idx(nbl_kind_t kind, logic [3:0] x, logic [3:0] y);
		unique case (kind)
			KIND_LUMA4: return {y[3], x[3], y[2], x[2]};
			KIND_LUMA8: return {2'b00, y[3], x[3]};
			KIND_CHROMA, KIND_NONE: return {y[3:2], 1'b0} + {2'b00, x[3:2]};
		endcase
	endfunction

endpackage
`default_nettype wire

FILE: sv/nbl_geom.sv
`default_nettype none
module nbl_geom (
	input  wire nbl_pkg::nbl_kind_t kind,
	input  wire logic [3:0]         block_index,
	input  wire logic               chroma_w16,
	input  wire logic               chroma_h16,
	output nbl_pkg::nbl_geom_t      geom
);

	always_comb begin
		logic [3:0] x, y, xm, ym;
		logic [2:0] b;
		b  = {chroma_h16 & block_index[2], block_index[1:0]};
		x  = '0;
		y  = '0;
		xm = 4'd15;
		ym = 4'd15;
		geom.kill = 1'b0;
		unique case (kind)
			nbl_pkg::KIND_LUMA4: begin
				x = {block_index[2], block_index[0], 2'b00};
				y = {block_index[3], block_index[1], 2'b00};
			end
			nbl_pkg::KIND_LUMA8: begin
				x = {block_index[0], 3'b000};
				y = {block_index[1], 3'b000};
			end
			nbl_pkg::KIND_CHROMA: begin
				x  = {1'b0, b[0], 2'b00};
				y  = {b[2:1], 2'b00};
				xm = chroma_w16 ? 4'd15 : 4'd7;
				ym = chroma_h16 ? 4'd15 : 4'd7;
			end
			nbl_pkg::KIND_NONE: geom.kill = 1'b1;
		endcase
		geom.x_zero    = (x == 4'd0);
		geom.y_zero    = (y == 4'd0);
		// edge case reads the far column/row of the neighbour macroblock
		geom.left_idx  = geom.x_zero ? nbl_pkg::blk_idx(kind, xm, y)
		                             : nbl_pkg::blk_idx(kind, x - 4'd1, y);
		geom.above_idx = geom.y_zero ? nbl_pkg::blk_idx(kind, x, ym)
		                             : nbl_pkg::blk_idx(kind, x, y - 4'd1);
	end

endmodule
`default_nettype wire

FILE: sv/nbl_div_stage.sv
`default_nettype none
// Restoring remainder steps for numerator bits BIT_HI down to BIT_HI-NSTEP+1.
module nbl_div_stage #(
	parameter int BIT_HI = 12,
	parameter int NSTEP  = 5
) (
	input  wire logic [nbl_pkg::ADDR_W-1:0]  num,
	input  wire logic [nbl_pkg::WIDTH_W-1:0] den,
	input  wire logic [nbl_pkg::REM_W-1:0]   rem_in,
	output logic      [nbl_pkg::REM_W-1:0]   rem_out
);

	always_comb begin
		logic [nbl_pkg::REM_W-1:0] r;
		r = rem_in;
		for (int i = 0; i < NSTEP; i++) begin
			r = {r[nbl_pkg::REM_W-2:0], num[BIT_HI-i]};
			if (r >= {1'b0, den})
				r = r - {1'b0, den};
		end
		rem_out = r;
	end

endmodule
`default_nettype wire

FILE: sv/h264_neighbour_block_locator_core.sv
// Each input transfer passes through five register stages: input capture, three
// remainder stages and the output register, which holds the result.
// Throughput: one item per cycle; the address modulo picture width is spread as
// 13 restoring steps over three stages. A stall at the output freezes every stage.
// Reset (arst_n low, asynchronous): pipeline empties, width reads 1, chroma sizes 8.
`default_nettype none
`include "h264_neighbour_block_locator_core_assert.svh"
module h264_neighbour_block_locator_core #(
	parameter int MAX_MACROBLOCKS = 8192
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration writes
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [9:0]        cfg_data,
	// query channel
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic [1:0]        action,
	input  wire logic [12:0]       current_mb_address,
	input  wire logic [3:0]        block_index,
	// result channel
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output logic signed [13:0]     left_mb_address,
	output logic signed [4:0]      left_block_index,
	output logic signed [13:0]     above_mb_address,
	output logic signed [4:0]      above_block_index,
	output logic signed [13:0]     upper_right_mb_address,
	output logic signed [13:0]     upper_left_mb_address
);

	// ---------------------------------------------------------------
	// Configuration registers, raw as written
	// ---------------------------------------------------------------
	logic [nbl_pkg::WIDTH_W-1:0] pic_width_q;
	logic [nbl_pkg::CSIZE_W-1:0] chroma_w_q;
	logic [nbl_pkg::CSIZE_W-1:0] chroma_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pic_width_q <= 10'd1;
			chroma_w_q  <= 5'd8;
			chroma_h_q  <= 5'd8;
		end else if (cfg_we) begin
			if (cfg_index == nbl_pkg::REG_PIC_WIDTH)
				pic_width_q <= cfg_data;
			else if (cfg_index == nbl_pkg::REG_CHROMA_W)
				chroma_w_q <= cfg_data[nbl_pkg::CSIZE_W-1:0];
			else if (cfg_index == nbl_pkg::REG_CHROMA_H)
				chroma_h_q <= cfg_data[nbl_pkg::CSIZE_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Stall control: all stages advance together unless the output
	// register holds a result the consumer has not taken.
	// ---------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic adv;

	assign adv       = !valid_s5 || rsp_ready;
	assign req_ready = adv;
	assign rsp_valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1 input: block geometry and candidate neighbour indexes.
	// The width and the geometry derived from the chroma flags travel with the item.
	// ---------------------------------------------------------------
	nbl_pkg::nbl_geom_t geom_in;
	nbl_pkg::nbl_item_t item_in;
	logic               addr_out_of_range;

	nbl_geom u_geom (
		.kind        (nbl_pkg::nbl_kind_t'(action)),
		.block_index (block_index),
		.chroma_w16  (chroma_w_q[4]),
		.chroma_h16  (chroma_h_q[4]),
		.geom        (geom_in)
	);

	assign addr_out_of_range = (int'(current_mb_address) >= MAX_MACROBLOCKS);

	always_comb begin
		item_in           = '0;
		item_in.geom      = geom_in;
		item_in.geom.kill = geom_in.kill || addr_out_of_range;
		item_in.cur       = current_mb_address;
		// a zero width acts as one macroblock per row
		item_in.w         = (pic_width_q == '0) ? 10'd1 : pic_width_q;
		item_in.rem       = '0;
	end

	nbl_pkg::nbl_item_t item_s1, item_s2, item_s3, item_s4;
	nbl_pkg::nbl_item_t item_a_d, item_b_d, item_c_d;
	logic [nbl_pkg::REM_W-1:0] rem_a, rem_b, rem_c;

	// ---------------------------------------------------------------
	// Stages 2..4: cur % w, 5 + 4 + 4 restoring steps
	// ---------------------------------------------------------------
	nbl_div_stage #(.BIT_HI(12), .NSTEP(5)) u_div_a (
		.num (item_s1.cur), .den (item_s1.w), .rem_in ('0), .rem_out (rem_a)
	);
	nbl_div_stage #(.BIT_HI(7), .NSTEP(4)) u_div_b (
		.num (item_s2.cur), .den (item_s2.w), .rem_in (item_s2.rem), .rem_out (rem_b)
	);
	nbl_div_stage #(.BIT_HI(3), .NSTEP(4)) u_div_c (
		.num (item_s3.cur), .den (item_s3.w), .rem_in (item_s3.rem), .rem_out (rem_c)
	);

	// partial remainder merged into the item moving to the next stage
	always_comb begin
		item_a_d     = item_s1;
		item_a_d.rem = rem_a;
		item_b_d     = item_s2;
		item_b_d.rem = rem_b;
		item_c_d     = item_s3;
		item_c_d.rem = rem_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item_in;
			item_s2 <= item_a_d;
			item_s3 <= item_b_d;
			item_s4 <= item_c_d;
		end
	end

	// ---------------------------------------------------------------
	// Stage 5: neighbour macroblocks A..D and the final selection
	// ---------------------------------------------------------------
	logic signed [13:0] cur_x, w_x;
	logic               col_first, col_last, has_row_above, past_first;
	logic signed [13:0] mb_a, mb_b, mb_c, mb_d;
	logic signed [13:0] left_mb_d, above_mb_d;
	logic signed [4:0]  left_idx_d, above_idx_d;

	always_comb begin
		cur_x         = {1'b0, item_s4.cur};
		w_x           = {4'b0000, item_s4.w};
		col_first     = (item_s4.rem == '0);
		col_last      = (item_s4.rem == ({1'b0, item_s4.w} - 11'd1));
		has_row_above = ({3'b000, item_s4.w} <= item_s4.cur);
		past_first    = ({3'b000, item_s4.w} <  item_s4.cur);

		mb_a = col_first ? nbl_pkg::ADDR_NONE : cur_x - 14'sd1;
		mb_b = has_row_above ? cur_x - w_x : nbl_pkg::ADDR_NONE;
		mb_c = (has_row_above && !col_last) ? cur_x - w_x + 14'sd1 : nbl_pkg::ADDR_NONE;
		mb_d = (past_first && !col_first) ? cur_x - w_x - 14'sd1 : nbl_pkg::ADDR_NONE;

		if (item_s4.geom.x_zero) begin
			left_mb_d  = mb_a;
			left_idx_d = col_first ? nbl_pkg::IDX_NONE : {1'b0, item_s4.geom.left_idx};
		end else begin
			left_mb_d  = cur_x;
			left_idx_d = {1'b0, item_s4.geom.left_idx};
		end

		if (item_s4.geom.y_zero) begin
			above_mb_d  = mb_b;
			above_idx_d = has_row_above ? {1'b0, item_s4.geom.above_idx} : nbl_pkg::IDX_NONE;
		end else begin
			above_mb_d  = cur_x;
			above_idx_d = {1'b0, item_s4.geom.above_idx};
		end

		// unknown kind or address at or beyond MAX_MACROBLOCKS
		if (item_s4.geom.kill) begin
			left_mb_d   = nbl_pkg::ADDR_NONE;
			left_idx_d  = nbl_pkg::IDX_NONE;
			above_mb_d  = nbl_pkg::ADDR_NONE;
			above_idx_d = nbl_pkg::IDX_NONE;
			mb_c        = nbl_pkg::ADDR_NONE;
			mb_d        = nbl_pkg::ADDR_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_mb_address        <= left_mb_d;
			left_block_index       <= left_idx_d;
			above_mb_address       <= above_mb_d;
			above_block_index      <= above_idx_d;
			upper_right_mb_address <= mb_c;
			upper_left_mb_address  <= mb_d;
		end
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`NBL_ASSERT(a_rem_in_range,
		valid_s4 |-> ({1'b0, item_s4.w} > item_s4.rem),
		"remainder not below width")
	`NBL_ASSERT(a_left_none,
		(rsp_valid && left_mb_address == nbl_pkg::ADDR_NONE)
			|-> (left_block_index == nbl_pkg::IDX_NONE),
		"left index given without left macroblock")
	`NBL_ASSERT(a_above_none,
		(rsp_valid && above_mb_address == nbl_pkg::ADDR_NONE)
			|-> (above_block_index == nbl_pkg::IDX_NONE),
		"above index given without above macroblock")
	`NBL_ASSERT(a_d_needs_b,
		(rsp_valid && upper_left_mb_address != nbl_pkg::ADDR_NONE)
			|-> (above_mb_address != nbl_pkg::ADDR_NONE),
		"D available while above is not")
	`NBL_ASSERT_ANY(a_reset_empty, !arst_n |-> !rsp_valid, "result valid during reset")

endmodule
`default_nettype wire
